[src/tlb_fifo_lru_replacement_defines.svh]
// assertion macros for the translation buffer checker
`ifndef TLB_FIFO_LRU_REPLACEMENT_DEFINES_SVH
`define TLB_FIFO_LRU_REPLACEMENT_DEFINES_SVH

// property checked on every clock edge outside reset
`define TLBFL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define TLBFL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tlbfl_pkg.sv]
// constants shared by the translation buffer and its checker
package tlbfl_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KEY_W   = 20;
    localparam int FRAME_W = 20;
    localparam int CNT_W   = 32;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(ENTRIES - 1);

    // operation codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FILL   = 1'b1;

endpackage

[src/tlb_fifo_lru_replacement.sv]
// fully associative translation buffer with fifo or lru replacement
// done follows an accepted request through the request register and the result register
// throughput: one request per cycle, busy stays low; the 8-way key compare, victim
// choice and recency update sit in the combinational logic between the request and result registers
// results last one cycle and cannot be stalled
// reset: all slots never filled, recency rank equals slot index, pointer and counters zero
module tlb_fifo_lru_replacement (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [tlbfl_pkg::KEY_W-1:0]   page_key,
    input  logic [tlbfl_pkg::FRAME_W-1:0] frame_in,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    output logic                        done,
    output logic                        hit,
    output logic [tlbfl_pkg::FRAME_W-1:0] frame_out,
    output logic [tlbfl_pkg::CNT_W-1:0]   lookups_total,
    output logic [tlbfl_pkg::CNT_W-1:0]   hits_total
);
    import tlbfl_pkg::*;

    // request register
    logic               req_valid_reg;
    logic               req_func_reg;
    logic [KEY_W-1:0]   req_key_reg;
    logic [FRAME_W-1:0] req_frame_reg;

    // translation state
    logic [KEY_W-1:0]   key_reg   [ENTRIES];
    logic [FRAME_W-1:0] frame_reg [ENTRIES];
    logic [ENTRIES-1:0] filled_reg, filled_next;
    logic [IDX_W-1:0]   rank_reg  [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [IDX_W-1:0]   fifo_ptr_reg, fifo_ptr_next;
    logic [CNT_W-1:0]   lookup_cnt_reg, lookup_cnt_next;
    logic [CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic               use_lru_reg;

    // result register
    logic               done_reg;
    logic               hit_reg, hit_next;
    logic [FRAME_W-1:0] frame_out_reg, frame_out_next;

    // per-request decode
    logic [ENTRIES-1:0] match;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic               free_any;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   oldest_idx;
    logic [IDX_W-1:0]   fill_idx;
    logic [IDX_W-1:0]   slot;
    logic [IDX_W-1:0]   old_rank;
    logic               is_lookup;
    logic               key_nz;
    logic               counted;
    logic               lookup_hit;
    logic               do_fill;
    logic               touch;

    // one request per cycle, never held off
    assign busy = 1'b0;

    always_comb
    begin
        is_lookup = (req_func_reg == FUNC_LOOKUP);
        key_nz    = (req_key_reg != '0);

        // lowest matching filled slot wins
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = filled_reg[i] && (key_reg[i] == req_key_reg);
            if (match[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end

        // lru victim: lowest never-filled slot, else the rank-zero slot
        free_any   = 1'b0;
        free_idx   = '0;
        oldest_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!filled_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (rank_reg[i] == '0)
            begin
                oldest_idx = IDX_W'(i);
            end
        end

        if (use_lru_reg)
        begin
            fill_idx = free_any ? free_idx : oldest_idx;
        end
        else
        begin
            fill_idx = fifo_ptr_reg;
        end

        counted    = req_valid_reg && is_lookup && key_nz;
        lookup_hit = counted && hit_any;
        do_fill    = req_valid_reg && !is_lookup;
        touch      = lookup_hit || do_fill;
        slot       = is_lookup ? hit_idx : fill_idx;
        old_rank   = rank_reg[slot];

        // move the touched slot to the top of the recency order
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (touch && (rank_reg[i] > old_rank))
            begin
                rank_next[i] = rank_reg[i] - 1'b1;
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
        end
        if (touch)
        begin
            rank_next[slot] = RANK_MAX;
        end

        filled_next = filled_reg;
        if (do_fill)
        begin
            filled_next[slot] = 1'b1;
        end

        fifo_ptr_next = fifo_ptr_reg;
        if (do_fill && !use_lru_reg)
        begin
            fifo_ptr_next = (fifo_ptr_reg == RANK_MAX) ? '0 : fifo_ptr_reg + 1'b1;
        end

        // saturating counters
        lookup_cnt_next = lookup_cnt_reg;
        if (counted && (lookup_cnt_reg != CNT_MAX))
        begin
            lookup_cnt_next = lookup_cnt_reg + 1'b1;
        end
        hit_cnt_next = hit_cnt_reg;
        if (lookup_hit && (hit_cnt_reg != CNT_MAX))
        begin
            hit_cnt_next = hit_cnt_reg + 1'b1;
        end

        hit_next       = lookup_hit;
        frame_out_next = lookup_hit ? frame_reg[hit_idx] : '0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
            filled_reg     <= '0;
            fifo_ptr_reg   <= '0;
            lookup_cnt_reg <= '0;
            hit_cnt_reg    <= '0;
            use_lru_reg    <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            req_valid_reg  <= start && !busy;
            done_reg       <= req_valid_reg;
            filled_reg     <= filled_next;
            fifo_ptr_reg   <= fifo_ptr_next;
            lookup_cnt_reg <= lookup_cnt_next;
            hit_cnt_reg    <= hit_cnt_next;
            rank_reg       <= rank_next;
            if (cfg_we)
            begin
                use_lru_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, qualified by the valid bits above
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_func_reg  <= func;
            req_key_reg   <= page_key;
            req_frame_reg <= frame_in;
        end
        if (do_fill)
        begin
            key_reg[slot]   <= req_key_reg;
            frame_reg[slot] <= req_frame_reg;
        end
        hit_reg       <= hit_next;
        frame_out_reg <= frame_out_next;
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_out     = frame_out_reg;
    assign lookups_total = lookup_cnt_reg;
    assign hits_total    = hit_cnt_reg;

endmodule

[src/tlbfl_checker.sv]
// port-level checks for the translation buffer, bound to the top level
`include "tlb_fifo_lru_replacement_defines.svh"

module tlbfl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          hit,
    input logic [tlbfl_pkg::FRAME_W-1:0] frame_out,
    input logic [tlbfl_pkg::CNT_W-1:0]   lookups_total,
    input logic [tlbfl_pkg::CNT_W-1:0]   hits_total
);
    import tlbfl_pkg::*;

    // every request gets its result once it has passed the request and result registers
    `TLBFL_ASSERT(a_result_latency, (start && !busy) |-> ##2 done, "request produced no result")
    // no result without an accepted request behind it
    `TLBFL_ASSERT(a_no_spurious, done |-> $past(start && !busy, 2), "result without request")
    // a hit is only shown with a result and a counted lookup behind it
    `TLBFL_ASSERT(a_hit_framed, hit |-> (done && (lookups_total != '0) && (hits_total != '0)),
                  "hit outside a counted result")
    // hits never outrun lookups
    `TLBFL_ASSERT(a_hits_le_lookups, hits_total <= lookups_total, "hit count above lookups")
    // requests are never held off
    `TLBFL_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

bind tlb_fifo_lru_replacement tlbfl_checker u_tlbfl_checker (.*);

[bench/tb_tlb_fifo_lru_replacement.sv]
// testbench for the fully associative translation buffer with fifo and lru replacement
`timescale 1ns / 100ps

module tb_tlb_fifo_lru_replacement;

    import tlbfl_pkg::*;

    // one translation result as the block reports it
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   lookups;
        logic [CNT_W-1:0]   hits;
    } xlat_result_t;

    // shadow copy of the buffer: predicts each result and checks what comes out
    class tlb_mirror;
        logic [KEY_W-1:0]   keys[ENTRIES];
        logic [FRAME_W-1:0] frames[ENTRIES];
        bit                 filled[ENTRIES];
        logic [IDX_W-1:0]   rank[ENTRIES];
        logic [IDX_W-1:0]   fifo_ptr;
        logic [CNT_W-1:0]   lookup_cnt;
        logic [CNT_W-1:0]   hit_cnt;
        bit                 use_lru;
        xlat_result_t       pending_results[$];
        int                 errors;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                keys[i]   = '0;
                frames[i] = '0;
                filled[i] = 1'b0;
                rank[i]   = IDX_W'(i);
            end
            fifo_ptr   = '0;
            lookup_cnt = '0;
            hit_cnt    = '0;
            use_lru    = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // slot becomes most recent, everything newer moves down one rank
        function void promote(int slot);
            logic [IDX_W-1:0] old_rank;
            old_rank = rank[slot];
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (rank[i] > old_rank)
                    rank[i] = rank[i] - 1'b1;
            end
            rank[slot] = RANK_MAX;
        endfunction

        // first never-filled slot, else the least recently used one
        function int lru_victim();
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!filled[i])
                    return i;
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (rank[i] == '0)
                    return i;
            end
            return 0;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] key, logic [FRAME_W-1:0] frame);
            xlat_result_t res;
            int           slot;
            res = '0;
            if (op == FUNC_LOOKUP)
            begin
                if (key != '0)
                begin
                    if (lookup_cnt != CNT_MAX)
                        lookup_cnt = lookup_cnt + 1'b1;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (filled[i] && keys[i] == key)
                        begin
                            res.hit   = 1'b1;
                            res.frame = frames[i];
                            if (hit_cnt != CNT_MAX)
                                hit_cnt = hit_cnt + 1'b1;
                            promote(i);
                            break;
                        end
                    end
                end
            end
            else
            begin
                if (use_lru)
                    slot = lru_victim();
                else
                begin
                    slot     = int'(fifo_ptr);
                    fifo_ptr = (slot == ENTRIES - 1) ? '0 : IDX_W'(slot + 1);
                end
                keys[slot]   = key;
                frames[slot] = frame;
                filled[slot] = 1'b1;
                promote(slot);
            end
            res.lookups = lookup_cnt;
            res.hits    = hit_cnt;
            pending_results.push_back(res);
        endfunction

        function void check_field(string name, logic [CNT_W-1:0] exp, logic [CNT_W-1:0] act);
            if (act !== exp)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(xlat_result_t act);
            xlat_result_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got hit %0b frame %0h",
                         $time, act.hit, act.frame);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            check_field("hit", CNT_W'(exp.hit), CNT_W'(act.hit));
            check_field("frame_out", CNT_W'(exp.frame), CNT_W'(act.frame));
            check_field("lookups_total", exp.lookups, act.lookups);
            check_field("hits_total", exp.hits, act.hits);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               func = FUNC_LOOKUP;
    logic [KEY_W-1:0]   page_key = '0;
    logic [FRAME_W-1:0] frame_in = '0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               done;
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic [CNT_W-1:0]   lookups_total;
    logic [CNT_W-1:0]   hits_total;

    tlb_mirror mirror = new();

    // percent chance per cycle that the sender holds off
    int idle_pct = 8;

    tlb_fifo_lru_replacement i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .page_key      (page_key),
        .frame_in      (frame_in),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .hit           (hit),
        .frame_out     (frame_out),
        .lookups_total (lookups_total),
        .hits_total    (hits_total)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // monitor: values seen at the edge are the ones the handshake used
    // results are checked before the request of the same edge is noted,
    // which is safe since a result always trails its request through the request and result registers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                mirror.check_result('{hit, frame_out, lookups_total, hits_total});
            if (start && busy === 1'b0)
                mirror.note_request(func, page_key, frame_in);
        end
    end

    // sender holds off at random, one cycle at a time
    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // one request, held until the block takes it; start stays high afterwards
    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [FRAME_W-1:0] frame);
        sender_gap();
        start    <= 1'b1;
        func     <= op;
        page_key <= key;
        frame_in <= frame;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // stop sending until every predicted result has come back
    // one edge first so the monitor has noted the last request taken
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0)
            @(posedge clk);
    endtask

    // policy change only with the pipe empty
    task automatic set_policy(input logic lru);
        drain_results();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lru;
        @(posedge clk);
        cfg_we         <= 1'b0;
        mirror.use_lru  = lru;
    endtask

    // mostly keys from a small pool around base so lookups hit often,
    // some wide random keys and a few zero keys
    function automatic logic [KEY_W-1:0] pick_key(logic [KEY_W-1:0] base);
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return KEY_W'($urandom);
        return base ^ KEY_W'($urandom_range(1, 12));
    endfunction

    // run watchdog
    initial
    begin
        #2_000_000;
        $display("tlb_fifo_lru_replacement test failed");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] base;
        logic             op;
        int               wait_cycles;
        int               leftover;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, fifo after reset
        send_request(FUNC_LOOKUP, 20'h00000, 20'hFFFFF);   // zero key not counted
        send_request(FUNC_LOOKUP, 20'hFFFFF, 20'h00000);   // miss on empty buffer
        send_request(FUNC_FILL,   20'h00000, 20'hFFFFF);   // zero key stored, never matches
        send_request(FUNC_LOOKUP, 20'h00000, 20'h00000);
        send_request(FUNC_FILL,   20'hFFFFF, 20'hFFFFF);
        send_request(FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
        send_request(FUNC_FILL,   20'h00001, 20'h00000);
        send_request(FUNC_LOOKUP, 20'h00001, 20'hFFFFF);   // hit with frame zero
        send_request(FUNC_FILL,   20'hFFFFF, 20'h5A5A5);   // duplicate key, lower slot wins
        send_request(FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
        send_request(FUNC_LOOKUP, 20'h12345, 20'h00000);

        // lru with half the slots never filled, then eviction by recency
        set_policy(1'b1);
        send_request(FUNC_FILL,   20'h80000, 20'h00001);
        send_request(FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
        send_request(FUNC_FILL,   20'h40000, 20'h80000);
        send_request(FUNC_FILL,   20'h00010, 20'h40000);
        send_request(FUNC_FILL,   20'hAAAAA, 20'h55555);
        send_request(FUNC_FILL,   20'h55555, 20'h0F0F0);
        send_request(FUNC_FILL,   20'h33333, 20'hF0F0F);
        send_request(FUNC_LOOKUP, 20'h00001, 20'h00000);
        send_request(FUNC_LOOKUP, 20'hAAAAA, 20'h00000);

        // back to fifo, the pointer picks up where it stood
        set_policy(1'b0);
        send_request(FUNC_FILL,   20'h77777, 20'h12345);
        send_request(FUNC_LOOKUP, 20'h77777, 20'h00000);
        send_request(FUNC_LOOKUP, 20'h80000, 20'h00000);

        // random blocks: policy alternates, sender idling 8 %, then 69 %, then none
        for (int blk = 0; blk < 6; blk++)
        begin
            idle_pct = (blk < 2) ? 8 : (blk < 4) ? 69 : 0;
            set_policy(blk[0] ? 1'b0 : 1'b1);
            base = KEY_W'($urandom);
            for (int n = 0; n < 75; n++)
            begin
                // sender pause until everything is back, once per block
                if (n == 37)
                    drain_results();
                op = ($urandom_range(99) < 35) ? FUNC_FILL : FUNC_LOOKUP;
                send_request(op, pick_key(base), FRAME_W'($urandom));
            end
        end

        // wait out the last results and a few more cycles for strays
        start <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 1000 && mirror.pending() != 0; wait_cycles++)
            @(posedge clk);
        repeat (4) @(posedge clk);

        leftover = mirror.pending();
        if (leftover != 0)
            $display("%0t: %0d expected results never arrived", $time, leftover);

        if (mirror.errors == 0 && leftover == 0)
            $display("tlb_fifo_lru_replacement test passed");
        else
            $display("tlb_fifo_lru_replacement test failed");
        $finish;
    end

endmodule
